// File: rtl/mjdc_pkg.sv
// Shared widths, constants, reciprocal factors and pipeline control type for the MJD converter.
package mjdc_pkg;

    // Field widths
    localparam int MJD_W      = 23;
    localparam int FRAC_IN_W  = 32;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 15;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int SEC_FRAC_W = 16;

    // Number of bits of the day fraction that carry weight (1 unit = 2^-FRACTION_BITS day)
    localparam int FRACTION_BITS = 32;
    localparam int FRAC_USED     = (FRACTION_BITS < FRAC_IN_W) ? FRACTION_BITS : FRAC_IN_W;
    // 86400 s * 2^16 = 675 * 2^23, so the tick count is frac * 675 scaled by 2^(23 - FRACTION_BITS)
    localparam int TOD_SHL   = (FRACTION_BITS <= 23) ? (23 - FRACTION_BITS) : 0;
    localparam int TOD_SHR   = (FRACTION_BITS > 23) ? (FRACTION_BITS - 23) : 0;
    localparam int TOD_P_W   = FRAC_USED + 10 + TOD_SHL;
    localparam int TICK_W    = 33;   // 2^-16 s ticks in a day stay below 675 * 2^23
    localparam int SEC_DAY_W = 17;   // whole seconds of the day, below 86400
    localparam int MIN_DAY_W = 11;   // whole minutes of the day, below 1440

    // Pipeline depth shared by the control and both datapaths
    localparam int NUM_STAGES = 8;

    // Day number limits
    localparam logic signed [MJD_W-1:0] MJD_LOW       = -23'sd2400000;
    localparam logic signed [MJD_W-1:0] MJD_HIGH      = 23'sd2973483;
    // JD 2299161 expressed as a modified day number
    localparam logic signed [MJD_W-1:0] MJD_GREGORIAN = -23'sd100840;

    // Internal widths of the date path
    localparam int JD_W   = 23;
    localparam int NUMB_W = 24;
    localparam int B_W    = 7;
    localparam int C_W    = 23;
    localparam int NUMD_W = 30;
    localparam int D_W    = 14;
    localparam int CE_W   = 9;
    localparam int F_W    = 4;

    // Reciprocal factors: floor(x / k) = (x * ceil(2^n / k)) >> n, exact while x * k <= 2^n
    localparam int B_SHIFT   = 42;
    localparam int B_RECIP_W = 25;
    localparam logic [B_RECIP_W-1:0] B_RECIP =
        B_RECIP_W'(((64'd1 << B_SHIFT) + 64'd146096) / 64'd146097);

    localparam int D_SHIFT   = 45;
    localparam int D_RECIP_W = 30;
    localparam logic [D_RECIP_W-1:0] D_RECIP =
        D_RECIP_W'(((64'd1 << D_SHIFT) + 64'd36524) / 64'd36525);

    // Folds the factor 10000 of the month step into the reciprocal of 306001
    localparam int F_SHIFT   = 41;
    localparam int F_RECIP_W = 37;
    localparam logic [F_RECIP_W-1:0] F_RECIP =
        F_RECIP_W'(64'd10000 * (((64'd1 << F_SHIFT) + 64'd306000) / 64'd306001));

    localparam int M_SHIFT   = 23;
    localparam int M_RECIP_W = 18;
    localparam logic [M_RECIP_W-1:0] M_RECIP =
        M_RECIP_W'(((64'd1 << M_SHIFT) + 64'd59) / 64'd60);

    localparam int H_SHIFT   = 17;
    localparam int H_RECIP_W = 12;
    localparam logic [H_RECIP_W-1:0] H_RECIP =
        H_RECIP_W'(((64'd1 << H_SHIFT) + 64'd59) / 64'd60);

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [HOUR_W-1:0]     hour;
        logic [MINUTE_W-1:0]   minute;
        logic [SECOND_W-1:0]   second;
        logic [SEC_FRAC_W-1:0] frac;
    } tod_t;

    // floor(30.6001 * f): day offset of the start of the shifted month f
    function automatic logic [CE_W-1:0] month_start(input logic [F_W-1:0] f);
        logic [CE_W-1:0] off;
        unique case (f)
            4'd1:    off = 9'd30;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd91;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd183;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd244;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd336;
            4'd12:   off = 9'd367;
            4'd13:   off = 9'd397;
            4'd14:   off = 9'd428;
            4'd15:   off = 9'd459;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/mjdc_ifs.sv
// Request and result channel interfaces of the MJD converter.
interface mjdc_req_if
    import mjdc_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [MJD_W-1:0]     mjd_day;
    logic        [FRAC_IN_W-1:0] day_fraction;

    modport source (output valid, output mjd_day, output day_fraction, input ready);
    modport sink   (input valid, input mjd_day, input day_fraction, output ready);
endinterface

interface mjdc_res_if
    import mjdc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic        [DAY_W-1:0]      day_of_month;
    logic        [MONTH_W-1:0]    month_number;
    logic signed [YEAR_W-1:0]     year_number;
    logic        [HOUR_W-1:0]     hour_of_day;
    logic        [MINUTE_W-1:0]   minute_of_hour;
    logic        [SECOND_W-1:0]   second_of_minute;
    logic        [SEC_FRAC_W-1:0] second_fraction;
    logic                         range_error;

    modport source (
        output valid, output day_of_month, output month_number, output year_number,
        output hour_of_day, output minute_of_hour, output second_of_minute,
        output second_fraction, output range_error, input ready
    );
    modport sink (
        input valid, input day_of_month, input month_number, input year_number,
        input hour_of_day, input minute_of_hour, input second_of_minute,
        input second_fraction, input range_error, output ready
    );
endinterface

// File: rtl/mjdc_date_pipe.sv
// Pipelined day-number to calendar-date datapath of the MJD converter.
module mjdc_date_pipe
    import mjdc_pkg::*;
(
    input  logic                     clk,
    input  pipe_ctrl_t               ctrl,
    input  logic signed [MJD_W-1:0]  mjd_day,
    output logic        [DAY_W-1:0]  day_of_month,
    output logic        [MONTH_W-1:0] month_number,
    output logic signed [YEAR_W-1:0] year_number,
    output logic                     range_error
);

    logic signed [MJD_W+1:0] mjd_wide;

    logic [JD_W-1:0]   s0_jd_reg,   s0_jd_next;
    logic [NUMB_W-1:0] s0_numb_reg, s0_numb_next;
    logic              s0_greg_reg, s0_greg_next;
    logic              s0_err_reg,  s0_err_next;

    logic [NUMB_W+B_RECIP_W-1:0] b_prod;
    logic [JD_W-1:0] s1_jd_reg;
    logic [B_W-1:0]  s1_b_reg, s1_b_next;
    logic            s1_greg_reg;
    logic            s1_err_reg;

    logic [C_W-1:0] s2_c_reg, s2_c_next;
    logic           s2_err_reg;

    logic [NUMD_W-1:0] s3_numd_reg, s3_numd_next;
    logic [C_W-1:0]    s3_c_reg;
    logic              s3_err_reg;

    logic [NUMD_W+D_RECIP_W-1:0] d_prod;
    logic [D_W-1:0] s4_d_reg, s4_d_next;
    logic [C_W-1:0] s4_c_reg;
    logic           s4_err_reg;

    logic [C_W-1:0]  year_start;
    logic [CE_W-1:0] s5_ce_reg, s5_ce_next;
    logic [D_W-1:0]  s5_d_reg;
    logic            s5_err_reg;

    logic [CE_W+F_RECIP_W-1:0] f_prod;
    logic [F_W-1:0]  s6_f_reg, s6_f_next;
    logic [CE_W-1:0] s6_ce_reg;
    logic [D_W-1:0]  s6_d_reg;
    logic            s6_err_reg;

    logic        [DAY_W-1:0]   day_reg,   day_next;
    logic        [MONTH_W-1:0] month_reg, month_next;
    logic        [YEAR_W-1:0]  year_reg,  year_next;
    logic                      err_reg;

    // Stage 0: day number, Gregorian numerator, range check
    always_comb
    begin
        mjd_wide     = {{2{mjd_day[MJD_W-1]}}, mjd_day};
        s0_jd_next   = JD_W'(mjd_wide + 25'sd2400001);
        // 4*JD - 7468865 taken straight from the modified day
        s0_numb_next = NUMB_W'((mjd_wide <<< 2) + 25'sd2131139);
        s0_greg_next = (mjd_day >= MJD_GREGORIAN);
        s0_err_next  = (mjd_day < MJD_LOW) || (mjd_day > MJD_HIGH);
    end

    // Stage 1: centuries correction
    always_comb
    begin
        b_prod    = (NUMB_W+B_RECIP_W)'(s0_numb_reg) * (NUMB_W+B_RECIP_W)'(B_RECIP);
        s1_b_next = B_W'(b_prod >> B_SHIFT);
    end

    // Stage 2: shifted day count
    always_comb
    begin
        if (s1_greg_reg)
        begin
            s2_c_next = C_W'(s1_jd_reg + C_W'(s1_b_reg) - C_W'(s1_b_reg >> 2) + 23'd1525);
        end
        else
        begin
            s2_c_next = C_W'(s1_jd_reg + 23'd1524);
        end
    end

    // Stage 3: year numerator
    always_comb
    begin
        s3_numd_next = NUMD_W'(NUMD_W'(s2_c_reg) * 30'd100 - 30'd12210);
    end

    // Stage 4: year count
    always_comb
    begin
        d_prod    = (NUMD_W+D_RECIP_W)'(s3_numd_reg) * (NUMD_W+D_RECIP_W)'(D_RECIP);
        s4_d_next = D_W'(d_prod >> D_SHIFT);
    end

    // Stage 5: day within the shifted year
    always_comb
    begin
        year_start = C_W'(C_W'(s4_d_reg) * 23'd365 + C_W'(s4_d_reg >> 2));
        s5_ce_next = CE_W'(s4_c_reg - year_start);
    end

    // Stage 6: shifted month
    always_comb
    begin
        f_prod    = (CE_W+F_RECIP_W)'(s5_ce_reg) * (CE_W+F_RECIP_W)'(F_RECIP);
        s6_f_next = F_W'(f_prod >> F_SHIFT);
    end

    // Stage 7: civil day, month and year; zero them on a range error
    always_comb
    begin
        day_next = DAY_W'(s6_ce_reg - month_start(s6_f_reg));
        if (s6_f_reg < 4'd14)
        begin
            month_next = MONTH_W'(s6_f_reg - 4'd1);
        end
        else
        begin
            month_next = MONTH_W'(s6_f_reg - 4'd13);
        end
        year_next = YEAR_W'(YEAR_W'(s6_d_reg) - 15'd4715 - YEAR_W'(month_next > 4'd2));
        if (s6_err_reg)
        begin
            day_next   = '0;
            month_next = '0;
            year_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[0])
        begin
            s0_jd_reg   <= s0_jd_next;
            s0_numb_reg <= s0_numb_next;
            s0_greg_reg <= s0_greg_next;
            s0_err_reg  <= s0_err_next;
        end
        if (ctrl.adv[1])
        begin
            s1_jd_reg   <= s0_jd_reg;
            s1_b_reg    <= s1_b_next;
            s1_greg_reg <= s0_greg_reg;
            s1_err_reg  <= s0_err_reg;
        end
        if (ctrl.adv[2])
        begin
            s2_c_reg   <= s2_c_next;
            s2_err_reg <= s1_err_reg;
        end
        if (ctrl.adv[3])
        begin
            s3_numd_reg <= s3_numd_next;
            s3_c_reg    <= s2_c_reg;
            s3_err_reg  <= s2_err_reg;
        end
        if (ctrl.adv[4])
        begin
            s4_d_reg   <= s4_d_next;
            s4_c_reg   <= s3_c_reg;
            s4_err_reg <= s3_err_reg;
        end
        if (ctrl.adv[5])
        begin
            s5_ce_reg  <= s5_ce_next;
            s5_d_reg   <= s4_d_reg;
            s5_err_reg <= s4_err_reg;
        end
        if (ctrl.adv[6])
        begin
            s6_f_reg   <= s6_f_next;
            s6_ce_reg  <= s5_ce_reg;
            s6_d_reg   <= s5_d_reg;
            s6_err_reg <= s5_err_reg;
        end
        if (ctrl.adv[7])
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            err_reg   <= s6_err_reg;
        end
    end

    assign day_of_month = day_reg;
    assign month_number = month_reg;
    assign year_number  = $signed(year_reg);
    assign range_error  = err_reg;

endmodule

// File: rtl/mjdc_tod_pipe.sv
// Pipelined day-fraction to time-of-day datapath of the MJD converter.
module mjdc_tod_pipe
    import mjdc_pkg::*;
(
    input  logic                  clk,
    input  pipe_ctrl_t            ctrl,
    input  logic [FRAC_IN_W-1:0]  day_fraction,
    output tod_t                  tod
);

    logic [TOD_P_W-1:0] ticks_wide;
    logic [TICK_W-1:0]  s0_ticks_reg, s0_ticks_next;

    logic [SEC_DAY_W+M_RECIP_W-1:0] m_prod;
    logic [SEC_DAY_W-1:0]  s1_sec_reg;
    logic [MIN_DAY_W-1:0]  s1_min_reg, s1_min_next;
    logic [SEC_FRAC_W-1:0] s1_frac_reg;

    logic [MIN_DAY_W+H_RECIP_W-1:0] h_prod;
    logic [HOUR_W-1:0]     s2_hour_reg, s2_hour_next;
    logic [SECOND_W-1:0]   s2_second_reg, s2_second_next;
    logic [MIN_DAY_W-1:0]  s2_min_reg;
    logic [SEC_FRAC_W-1:0] s2_frac_reg;

    tod_t s3_tod_next;
    tod_t s3_tod_reg, s4_tod_reg, s5_tod_reg, s6_tod_reg, s7_tod_reg;

    // Stage 0: scale the fraction to 2^-16 s ticks
    always_comb
    begin
        ticks_wide    = TOD_P_W'(TOD_P_W'(day_fraction[FRAC_USED-1:0]) * 10'd675) << TOD_SHL;
        s0_ticks_next = TICK_W'(ticks_wide >> TOD_SHR);
    end

    // Stage 1: whole minutes of the day
    always_comb
    begin
        m_prod = (SEC_DAY_W+M_RECIP_W)'(s0_ticks_reg[TICK_W-1:SEC_FRAC_W])
               * (SEC_DAY_W+M_RECIP_W)'(M_RECIP);
        s1_min_next = MIN_DAY_W'(m_prod >> M_SHIFT);
    end

    // Stage 2: hour and second
    always_comb
    begin
        h_prod         = (MIN_DAY_W+H_RECIP_W)'(s1_min_reg) * (MIN_DAY_W+H_RECIP_W)'(H_RECIP);
        s2_hour_next   = HOUR_W'(h_prod >> H_SHIFT);
        s2_second_next = SECOND_W'(s1_sec_reg - SEC_DAY_W'(s1_min_reg) * 17'd60);
    end

    // Stage 3: minute within the hour
    always_comb
    begin
        s3_tod_next.hour   = s2_hour_reg;
        s3_tod_next.minute = MINUTE_W'(s2_min_reg - MIN_DAY_W'(s2_hour_reg) * 11'd60);
        s3_tod_next.second = s2_second_reg;
        s3_tod_next.frac   = s2_frac_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[0])
        begin
            s0_ticks_reg <= s0_ticks_next;
        end
        if (ctrl.adv[1])
        begin
            s1_sec_reg  <= s0_ticks_reg[TICK_W-1:SEC_FRAC_W];
            s1_min_reg  <= s1_min_next;
            s1_frac_reg <= s0_ticks_reg[SEC_FRAC_W-1:0];
        end
        if (ctrl.adv[2])
        begin
            s2_hour_reg   <= s2_hour_next;
            s2_second_reg <= s2_second_next;
            s2_min_reg    <= s1_min_reg;
            s2_frac_reg   <= s1_frac_reg;
        end
        if (ctrl.adv[3])
        begin
            s3_tod_reg <= s3_tod_next;
        end
        // Hold the finished time alongside the date path
        if (ctrl.adv[4])
        begin
            s4_tod_reg <= s3_tod_reg;
        end
        if (ctrl.adv[5])
        begin
            s5_tod_reg <= s4_tod_reg;
        end
        if (ctrl.adv[6])
        begin
            s6_tod_reg <= s5_tod_reg;
        end
        if (ctrl.adv[7])
        begin
            s7_tod_reg <= s6_tod_reg;
        end
    end

    assign tod = s7_tod_reg;

endmodule

// File: rtl/mjd_to_calendar_date_time.sv
// Top level of the modified Julian day to civil date and time-of-day converter.
// Each request carries a whole modified Julian day and a binary fraction of the day; the
// block returns day, month and astronomical year (Julian calendar before JD 2299161,
// Gregorian from then on) together with hour, minute, second and a 2^-16 s fraction. A day
// outside -2400000..2973483 raises range_error and zeroes the date fields, while the time
// fields are still given. The block keeps no state between requests: it is an eight-stage
// pipeline that takes one request per clock unless a stalled result backs up its stages, and
// presents each result from the register of its last stage. The stage depth is set by the
// reciprocal multiplications that stand in for the divisions by 146097, 36525, 30.6001
// and 60, each multiplier with a register after it; the widest is the 30 by 30 bit
// product of the year count. Every stage has its own valid bit and moves on when it is
// empty or the stage after it moves, so bubbles close up and a stalled result holds in
// the output stage while earlier stages keep filling. No clearing pass is needed after
// reset: only the valid bits are reset.
module mjd_to_calendar_date_time
    import mjdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mjdc_req_if.sink      req,
    mjdc_res_if.source    res
);

    logic [NUM_STAGES-1:0] v_reg;
    pipe_ctrl_t            ctrl;
    tod_t                  tod;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        ctrl.adv[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || res.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ctrl.adv[i] = !v_reg[i] || ctrl.adv[i+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ctrl.adv[0])
            begin
                v_reg[0] <= req.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (ctrl.adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign req.ready = ctrl.adv[0];
    assign res.valid = v_reg[NUM_STAGES-1];

    mjdc_date_pipe u_date (
        .clk          (clk),
        .ctrl         (ctrl),
        .mjd_day      (req.mjd_day),
        .day_of_month (res.day_of_month),
        .month_number (res.month_number),
        .year_number  (res.year_number),
        .range_error  (res.range_error)
    );

    mjdc_tod_pipe u_tod (
        .clk          (clk),
        .ctrl         (ctrl),
        .day_fraction (req.day_fraction),
        .tod          (tod)
    );

    assign res.hour_of_day      = tod.hour;
    assign res.minute_of_hour   = tod.minute;
    assign res.second_of_minute = tod.second;
    assign res.second_fraction  = tod.frac;

    // Occupancy changes only with a request taken or a result delivered
    a_occupancy_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!(req.valid && req.ready) && !(res.valid && res.ready))
        |=> ($countones(v_reg) == $past($countones(v_reg))))
        else $error("pipeline occupancy changed without a transfer");

    // A request taken lands in the first stage
    a_request_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> v_reg[0])
        else $error("accepted request missing from first stage");

    // An out-of-range day leaves the date fields cleared
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.range_error)
        |-> (res.day_of_month == '0 && res.month_number == '0 && res.year_number == '0))
        else $error("date fields not cleared on range error");

    // A day in range gives a real day and month
    a_date_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.range_error)
        |-> (res.day_of_month >= 5'd1 && res.day_of_month <= 5'd31
             && res.month_number >= 4'd1 && res.month_number <= 4'd12))
        else $error("day or month out of bounds");

    // Time of day stays within its bounds
    a_time_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.hour_of_day <= 5'd23 && res.minute_of_hour <= 6'd59
                       && res.second_of_minute <= 6'd59))
        else $error("time of day out of bounds");

endmodule
